FILE: design/tbch_pkg.sv
// ============================================================================
// tbch_pkg
// Shared constants, types and helpers for the token block chain hash.
// ============================================================================
package tbch_pkg;

    localparam int MAX_BLOCK_TOKENS = 256;

    localparam int TOKEN_W = 32;
    localparam int COUNT_W = 9;
    localparam int WORD_W  = 64;

    localparam logic [31:0] MIX32_MUL   = 32'h045D_9F3B;
    localparam logic [63:0] MIX64_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX64_MUL_B = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] PARENT_MUL  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [31:0] COMBINE_ADD = 32'h9E37_79B9;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified token beat as the back end sees it
    typedef struct packed {
        logic                      first_token;
        logic                      last_token;
        logic signed [TOKEN_W-1:0] token_id;
        logic                      is_digest;
        logic [COUNT_W-1:0]        count_sat;
        logic [WORD_W-1:0]         parent_hash;
        logic                      salt_use;
        logic [WORD_W-1:0]         salt_id;
        logic                      has_adapter;
        logic [WORD_W-1:0]         adapter_id;
    } tbch_entry_t;

    // Push side of the queue
    typedef struct packed {
        logic        valid;
        tbch_entry_t entry;
    } tbch_push_t;

    // Pop side of the queue
    typedef struct packed {
        logic        valid;
        tbch_entry_t entry;
    } tbch_head_t;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] result;
        if (int'(count) > MAX_BLOCK_TOKENS)
        begin
            result = COUNT_W'(MAX_BLOCK_TOKENS);
        end
        else
        begin
            result = count;
        end
        return result;
    endfunction

endpackage

FILE: design/tbch_if.sv
// ============================================================================
// tbch_token_if / tbch_hash_if
// Valid/ready channels for token beats and hash result beats.
// ============================================================================
interface tbch_token_if;
    logic                                          valid;
    logic                                          ready;
    logic                                          first_token;
    logic                                          last_token;
    logic signed [tbch_pkg::TOKEN_W-1:0]           token_id;
    logic                                          is_digest;
    logic [tbch_pkg::COUNT_W-1:0]                  token_count;
    logic [tbch_pkg::WORD_W-1:0]                   parent_hash;
    logic                                          has_salt;
    logic [tbch_pkg::WORD_W-1:0]                   salt_id;
    logic                                          has_adapter;
    logic [tbch_pkg::WORD_W-1:0]                   adapter_id;

    modport source (
        output valid, first_token, last_token, token_id, is_digest, token_count,
               parent_hash, has_salt, salt_id, has_adapter, adapter_id,
        input  ready
    );
    modport sink (
        input  valid, first_token, last_token, token_id, is_digest, token_count,
               parent_hash, has_salt, salt_id, has_adapter, adapter_id,
        output ready
    );
endinterface

interface tbch_hash_if;
    logic                          valid;
    logic                          ready;
    logic [tbch_pkg::WORD_W-1:0]   block_hash;
    logic                          compatible;

    modport source (
        output valid, block_hash, compatible,
        input  ready
    );
    modport sink (
        input  valid, block_hash, compatible,
        output ready
    );
endinterface

FILE: design/tbch_front.sv
// ============================================================================
// tbch_front
// Accepts token beats, saturates the count and decides on salt use.
// ============================================================================
module tbch_front (
    tbch_token_if.sink          tokens,
    input  logic                queue_ready,
    output tbch_pkg::tbch_push_t push
);

    assign tokens.ready = queue_ready;

    always_comb
    begin
        push.valid             = tokens.valid && queue_ready;
        push.entry.first_token = tokens.first_token;
        push.entry.last_token  = tokens.last_token;
        push.entry.token_id    = tokens.token_id;
        push.entry.is_digest   = tokens.is_digest;
        push.entry.count_sat   = tbch_pkg::sat_count(tokens.token_count);
        push.entry.parent_hash = tokens.parent_hash;
        // salt only folds into a root block
        push.entry.salt_use    = tokens.has_salt && (tokens.parent_hash == '0);
        push.entry.salt_id     = tokens.salt_id;
        push.entry.has_adapter = tokens.has_adapter;
        push.entry.adapter_id  = tokens.adapter_id;
    end

endmodule

FILE: design/tbch_queue.sv
// ============================================================================
// tbch_queue
// Short FIFO of classified token beats between front and back.
// ============================================================================
module tbch_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbch_pkg::tbch_push_t push,
    output logic                 push_ready,
    output tbch_pkg::tbch_head_t head,
    input  logic                 pop
);

    tbch_pkg::tbch_entry_t              slot_reg [tbch_pkg::QUEUE_DEPTH];
    logic [tbch_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [tbch_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [tbch_pkg::QCNT_W-1:0]        fill_reg;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = (int'(fill_reg) < tbch_pkg::QUEUE_DEPTH);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    function automatic logic [tbch_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tbch_pkg::QPTR_W-1:0] ptr
    );
        logic [tbch_pkg::QPTR_W-1:0] result;
        if (int'(ptr) == tbch_pkg::QUEUE_DEPTH - 1)
        begin
            result = '0;
        end
        else
        begin
            result = ptr + 1'b1;
        end
        return result;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

FILE: design/tbch_back.sv
// ============================================================================
// tbch_back
// Sequencer over one shared 32x32 multiplier: seeds, folds tokens and words,
// and holds the result register.
// ============================================================================
module tbch_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbch_pkg::tbch_head_t head,
    output logic                 pop,
    tbch_hash_if.source          hashes
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_SEED,
        S_WA,
        S_WA_POST,
        S_WB,
        S_WADD,
        S_FIN,
        S_TOK,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_LAST,
        S_RES
    } state_t;

    typedef enum logic [1:0] {
        FOLD_SALT,
        FOLD_ADAPTER,
        FOLD_TOKEN
    } fold_t;

    state_t                 state_reg;
    fold_t                  fold_reg;
    tbch_pkg::tbch_entry_t  cur_reg;

    logic [63:0] seed_reg;
    logic        digest_seen_reg;
    logic        adapter_pending_reg;
    logic [63:0] adapter_value_reg;

    logic [63:0] mul_x_reg;
    logic [63:0] mul_y_reg;
    logic [63:0] acc_reg;
    logic [1:0]  mul_cnt_reg;
    logic [63:0] tmp_reg;

    logic [63:0] res_hash_reg;
    logic        res_compat_reg;
    logic        out_valid_reg;
    logic [63:0] out_hash_reg;
    logic        out_compat_reg;

    // partial products: lo*lo, lo*hi, hi*lo
    logic [31:0] pp_a;
    logic [31:0] pp_b;
    logic [63:0] pp;
    logic [63:0] acc_step;
    logic        mul_last;
    logic [63:0] fold_sum;
    logic [63:0] fold_res;
    logic [31:0] acc_lo;
    logic [31:0] acc_lo_mix;
    logic        res_load;

    always_comb
    begin
        pp_a     = (mul_cnt_reg == 2'd2) ? mul_x_reg[63:32] : mul_x_reg[31:0];
        pp_b     = (mul_cnt_reg == 2'd1) ? mul_y_reg[63:32] : mul_y_reg[31:0];
        pp       = {32'b0, pp_a} * {32'b0, pp_b};
        acc_step = (mul_cnt_reg == 2'd0) ? pp : (acc_reg + {pp[31:0], 32'b0});
        mul_last = (mul_cnt_reg == 2'd2);
        fold_sum = tmp_reg + (seed_reg << 6) + (seed_reg >> 2);
        fold_res = seed_reg ^ fold_sum;
        acc_lo     = acc_reg[31:0];
        acc_lo_mix = acc_lo ^ (acc_lo >> 16);
        // result moves to the output register once that register is free
        res_load   = (state_reg == S_RES) && (!out_valid_reg || hashes.ready);
    end

    assign pop               = (state_reg == S_IDLE) && head.valid;
    assign hashes.valid      = out_valid_reg;
    assign hashes.block_hash = out_hash_reg;
    assign hashes.compatible = out_compat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            fold_reg            <= FOLD_TOKEN;
            cur_reg             <= '0;
            seed_reg            <= '0;
            digest_seen_reg     <= 1'b0;
            adapter_pending_reg <= 1'b0;
            adapter_value_reg   <= '0;
            mul_x_reg           <= '0;
            mul_y_reg           <= '0;
            acc_reg             <= '0;
            mul_cnt_reg         <= '0;
            tmp_reg             <= '0;
            res_hash_reg        <= '0;
            res_compat_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
            out_hash_reg        <= '0;
            out_compat_reg      <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg  <= 1'b1;
                out_hash_reg   <= res_hash_reg;
                out_compat_reg <= res_compat_reg;
            end
            else if (out_valid_reg && hashes.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        cur_reg <= head.entry;
                        if (head.entry.first_token)
                        begin
                            digest_seen_reg     <= 1'b0;
                            adapter_pending_reg <= head.entry.has_adapter;
                            adapter_value_reg   <= head.entry.adapter_id;
                            mul_x_reg           <= head.entry.parent_hash;
                            mul_y_reg           <= tbch_pkg::PARENT_MUL;
                            mul_cnt_reg         <= '0;
                            state_reg           <= S_PMUL;
                        end
                        else
                        begin
                            state_reg <= S_TOK;
                        end
                    end
                end

                S_PMUL:
                begin
                    acc_reg     <= acc_step;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_last)
                    begin
                        state_reg <= S_SEED;
                    end
                end

                S_SEED:
                begin
                    seed_reg <= {55'b0, cur_reg.count_sat} ^ acc_reg;
                    if (cur_reg.salt_use)
                    begin
                        fold_reg    <= FOLD_SALT;
                        mul_x_reg   <= cur_reg.salt_id ^ (cur_reg.salt_id >> 30);
                        mul_y_reg   <= tbch_pkg::MIX64_MUL_A;
                        mul_cnt_reg <= '0;
                        state_reg   <= S_WA;
                    end
                    else
                    begin
                        state_reg <= S_TOK;
                    end
                end

                S_WA:
                begin
                    acc_reg     <= acc_step;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_last)
                    begin
                        state_reg <= S_WA_POST;
                    end
                end

                S_WA_POST:
                begin
                    mul_x_reg   <= acc_reg ^ (acc_reg >> 27);
                    mul_y_reg   <= tbch_pkg::MIX64_MUL_B;
                    mul_cnt_reg <= '0;
                    state_reg   <= S_WB;
                end

                S_WB:
                begin
                    acc_reg     <= acc_step;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_last)
                    begin
                        state_reg <= S_WADD;
                    end
                end

                S_WADD:
                begin
                    tmp_reg   <= (acc_reg ^ (acc_reg >> 31)) + {32'b0, tbch_pkg::COMBINE_ADD};
                    state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    unique case (fold_reg)
                        FOLD_ADAPTER:
                        begin
                            res_hash_reg   <= fold_res;
                            res_compat_reg <= 1'b1;
                            state_reg      <= S_RES;
                        end
                        FOLD_TOKEN:
                        begin
                            seed_reg  <= fold_res;
                            state_reg <= S_LAST;
                        end
                        default:
                        begin
                            seed_reg  <= fold_res;
                            state_reg <= S_TOK;
                        end
                    endcase
                end

                S_TOK:
                begin
                    if (digest_seen_reg)
                    begin
                        state_reg <= S_LAST;
                    end
                    else if (cur_reg.is_digest)
                    begin
                        digest_seen_reg <= 1'b1;
                        state_reg       <= S_LAST;
                    end
                    else
                    begin
                        mul_x_reg   <= {32'b0, cur_reg.token_id ^ (cur_reg.token_id >>> 0 >> 16)};
                        mul_y_reg   <= {32'b0, tbch_pkg::MIX32_MUL};
                        mul_cnt_reg <= '0;
                        state_reg   <= S_T1;
                    end
                end

                S_T1:
                begin
                    acc_reg   <= acc_step;
                    state_reg <= S_T2;
                end

                S_T2:
                begin
                    mul_x_reg <= {32'b0, acc_lo_mix};
                    state_reg <= S_T3;
                end

                S_T3:
                begin
                    acc_reg   <= acc_step;
                    state_reg <= S_T4;
                end

                S_T4:
                begin
                    tmp_reg   <= {32'b0, acc_lo_mix + tbch_pkg::COMBINE_ADD};
                    fold_reg  <= FOLD_TOKEN;
                    state_reg <= S_FIN;
                end

                S_LAST:
                begin
                    if (!cur_reg.last_token)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (digest_seen_reg)
                    begin
                        res_hash_reg   <= '0;
                        res_compat_reg <= 1'b0;
                        state_reg      <= S_RES;
                    end
                    else if (adapter_pending_reg)
                    begin
                        fold_reg    <= FOLD_ADAPTER;
                        mul_x_reg   <= adapter_value_reg ^ (adapter_value_reg >> 30);
                        mul_y_reg   <= tbch_pkg::MIX64_MUL_A;
                        mul_cnt_reg <= '0;
                        state_reg   <= S_WA;
                    end
                    else
                    begin
                        res_hash_reg   <= seed_reg;
                        res_compat_reg <= 1'b1;
                        state_reg      <= S_RES;
                    end
                end

                S_RES:
                begin
                    if (res_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/token_block_chain_hash.sv
// ============================================================================
// token_block_chain_hash
// Chained 64-bit key over one block of token ids.
// ============================================================================
// Token beats enter through a front end that saturates the token count and
// flags salt use, then wait in a two-entry queue for the back end. The back
// end is a sequencer around one 32x32 multiplier; a 64-bit product takes
// three passes (low*low, low*high, high*low). A plain token beat is mixed
// through the multiplier and folded into the seed. A block-start beat first
// runs the parent multiply, plus a salt fold when a salt is folded into a
// root block. A last beat then loads the result register, after an adapter
// fold when an adapter id is folded in. Input is accepted while the queue
// has room; a finished result sits in the output register and the next
// beats keep flowing until the back end needs that register again. A
// digest beat marks the block incompatible: the result then carries hash 0
// and compatible 0, and later beats of the block are skipped. Beats after a
// last beat without a new block start continue from the seed left behind
// (adapter not included).
// ============================================================================
module token_block_chain_hash (
    input  logic         clk,
    input  logic         rst_n,
    tbch_token_if.sink   tokens,
    tbch_hash_if.source  hashes
);

    tbch_pkg::tbch_push_t push;
    tbch_pkg::tbch_head_t head;
    logic                 queue_ready;
    logic                 pop;

    // classify and hand off
    tbch_front u_front (
        .tokens      (tokens),
        .queue_ready (queue_ready),
        .push        (push)
    );

    // decouples acceptance from the multiplier sequencer
    tbch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (queue_ready),
        .head       (head),
        .pop        (pop)
    );

    // seed, token and word folds; result register
    tbch_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .hashes (hashes)
    );

endmodule

FILE: tb/tbch_hash_checker.sv
// ============================================================================
// tbch_hash_checker
// Watches the token and hash channels, predicts each block key and compares.
// ============================================================================
module tbch_hash_checker (
    input  logic  clk,
    input  logic  rst_n,
    tbch_token_if tokens,
    tbch_hash_if  hashes,
    output int    errors,
    output int    pending,
    output int    hashes_checked,
    output int    aborted_blocks
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SCRAMBLE32   = 32'h045D_9F3B;
    localparam logic [31:0] GOLDEN32     = 32'h9E37_79B9;
    localparam logic [63:0] SPLIT_A      = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SPLIT_B      = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] PARENT_SCALE = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [tbch_pkg::COUNT_W-1:0] COUNT_CAP = 9'd256;
    localparam int          PRINT_CAP    = 100;

    typedef struct packed {
        logic [tbch_pkg::WORD_W-1:0] block_hash;
        logic                        compatible;
    } block_key_t;

    block_key_t expected_keys[$];

    // running chain state
    logic [63:0] chain_seed;
    logic        block_aborted;
    logic        adapter_armed;
    logic [63:0] adapter_word;

    function automatic logic [31:0] avalanche32(input logic [31:0] x);
        logic [31:0] v;
        v = x;
        v = ((v >> 16) ^ v) * SCRAMBLE32;
        v = ((v >> 16) ^ v) * SCRAMBLE32;
        v = (v >> 16) ^ v;
        return v + GOLDEN32;    // wraps at 32 bits
    endfunction

    function automatic logic [63:0] fold_token(input logic [31:0] tok, input logic [63:0] seed);
        logic [63:0] mixed;
        mixed = {32'h0, avalanche32(tok)};
        return seed ^ (mixed + (seed << 6) + (seed >> 2));
    endfunction

    function automatic logic [63:0] splitmix_fold(input logic [63:0] word,
                                                  input logic [63:0] seed);
        logic [63:0] v;
        v = word;
        v = (v ^ (v >> 30)) * SPLIT_A;
        v = (v ^ (v >> 27)) * SPLIT_B;
        v = v ^ (v >> 31);
        return seed ^ (v + {32'h0, GOLDEN32} + (seed << 6) + (seed >> 2));
    endfunction

    // one line per mismatch; beyond the cap they are only counted
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < PRINT_CAP)
        begin
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        end
        errors++;
    endtask

    task automatic absorb_token_beat();
        logic [tbch_pkg::COUNT_W-1:0] count;
        block_key_t                   key;
        if (tokens.first_token)
        begin
            count = (tokens.token_count > COUNT_CAP) ? COUNT_CAP : tokens.token_count;
            chain_seed = {55'h0, count} ^ (tokens.parent_hash * PARENT_SCALE);
            if (tokens.parent_hash == 64'h0 && tokens.has_salt)
            begin
                chain_seed = splitmix_fold(tokens.salt_id, chain_seed);
            end
            block_aborted = 1'b0;
            adapter_armed = tokens.has_adapter;
            adapter_word  = tokens.adapter_id;
        end
        if (!block_aborted)
        begin
            if (tokens.is_digest)
            begin
                block_aborted = 1'b1;
            end
            else
            begin
                chain_seed = fold_token(tokens.token_id, chain_seed);
            end
        end
        if (tokens.last_token)
        begin
            key.compatible = !block_aborted;
            key.block_hash = block_aborted ? 64'h0 :
                             adapter_armed ? splitmix_fold(adapter_word, chain_seed) :
                                             chain_seed;
            expected_keys = {expected_keys, key};
        end
    endtask

    task automatic check_hash_beat();
        block_key_t want;
        hashes_checked++;
        if (expected_keys.size() == 0)
        begin
            report_mismatch("hash beat with no block pending", hashes.block_hash, 64'h0);
        end
        else
        begin
            want = expected_keys.pop_front();
            if (!want.compatible)
            begin
                aborted_blocks++;
            end
            if (hashes.block_hash !== want.block_hash)
            begin
                report_mismatch("block_hash", hashes.block_hash, want.block_hash);
            end
            if (hashes.compatible !== want.compatible)
            begin
                report_mismatch("compatible", 64'(hashes.compatible), 64'(want.compatible));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_seed    = 64'h0;
            block_aborted = 1'b0;
            adapter_armed = 1'b0;
            adapter_word  = 64'h0;
            expected_keys.delete();
            pending       = 0;
        end
        else
        begin
            if (tokens.valid && tokens.ready)
            begin
                absorb_token_beat();
            end
            if (hashes.valid && hashes.ready)
            begin
                check_hash_beat();
            end
            pending = expected_keys.size();
        end
    end

endmodule

FILE: tb/token_block_chain_hash_test.sv
// ============================================================================
// token_block_chain_hash_test
// Stimulus and verdict for the token block chain hash.
// ============================================================================
// Drives token beats into the block and takes hash beats out of it, with
// random idle cycles on both channels. A directed opening covers the field
// extremes and the corner cases of the chaining; random blocks follow,
// mostly well-formed, the rest stray tokens and blocks left open. The
// checker beside the block predicts every key and counts mismatches.
// ============================================================================
module token_block_chain_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIVE_BEAT_GOAL = 1150;
    localparam int DRAIN_EVERY    = 250;   // sender waits for all keys this often
    localparam int SETTLE_CYCLES  = 120;   // margin for beats still in the queue of 2 and the back end

    typedef struct {
        logic               first_token;
        logic               last_token;
        logic signed [31:0] token_id;
        logic               is_digest;
        logic [8:0]         token_count;
        logic [63:0]        parent_hash;
        logic               has_salt;
        logic [63:0]        salt_id;
        logic               has_adapter;
        logic [63:0]        adapter_id;
    } token_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    tbch_token_if tok_ch ();
    tbch_hash_if  hash_ch ();

    int errors;
    int pending;
    int hashes_checked;
    int aborted_blocks;

    // stimulus bookkeeping
    int  beats_sent;
    int  live_beats;      // beats the block actually folds or flags
    int  blocks_started;
    int  digest_beats;
    int  src_mode;
    int  sink_mode;
    int  keys_taken;
    bit  skipping;        // inside a block already marked incompatible

    token_block_chain_hash dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tokens (tok_ch),
        .hashes (hash_ch)
    );

    tbch_hash_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .tokens         (tok_ch),
        .hashes         (hash_ch),
        .errors         (errors),
        .pending        (pending),
        .hashes_checked (hashes_checked),
        .aborted_blocks (aborted_blocks)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10ms;
        $display("run limit reached with %0d keys outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mode 0 never idles, mode 1 draws a random idle gap before every beat, mode 2 idles rarely.
    function automatic int idle_gap(input int mode);
        if (mode == 0)
        begin
            return 0;
        end
        else if (mode == 1)
        begin
            return $urandom_range(0, 19);
        end
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Zero (root block) often, all ones now and then, otherwise random.
    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return 64'h0;
        end
        else if (r == 3)
        begin
            return '1;
        end
        return random_word();
    endfunction

    // Random token id and block fields, flags clear; block fields on a non-start beat must be ignored.
    function automatic token_beat_t filler_beat();
        token_beat_t b;
        b.first_token = 1'b0;
        b.last_token  = 1'b0;
        b.token_id    = $urandom;
        b.is_digest   = 1'b0;
        b.token_count = 9'($urandom_range(0, 511));
        b.parent_hash = random_word();
        b.has_salt    = 1'($urandom_range(0, 1));
        b.salt_id     = random_word();
        b.has_adapter = 1'($urandom_range(0, 1));
        b.adapter_id  = random_word();
        return b;
    endfunction

    // Drive one beat at the falling edge and hold it until accepted. Fields
    // are driven with blocking writes at the falling edge, so the block
    // always samples settled values at the rising edge.
    task automatic drive_beat(input token_beat_t b);
        int gap;
        if (beats_sent % 60 == 0)
        begin
            src_mode = $urandom_range(0, 2);
        end
        gap = idle_gap(src_mode);
        if (gap > 0)
        begin
            @(negedge clk);
            tok_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        tok_ch.first_token = b.first_token;
        tok_ch.last_token  = b.last_token;
        tok_ch.token_id    = b.token_id;
        tok_ch.is_digest   = b.is_digest;
        tok_ch.token_count = b.token_count;
        tok_ch.parent_hash = b.parent_hash;
        tok_ch.has_salt    = b.has_salt;
        tok_ch.salt_id     = b.salt_id;
        tok_ch.has_adapter = b.has_adapter;
        tok_ch.adapter_id  = b.adapter_id;
        tok_ch.valid       = 1'b1;
        do @(posedge clk); while (!tok_ch.ready);

        beats_sent++;
        if (b.first_token)
        begin
            skipping = 1'b0;
            blocks_started++;
        end
        if (!skipping)
        begin
            live_beats++;
        end
        if (b.is_digest)
        begin
            skipping = 1'b1;
            digest_beats++;
        end
    endtask

    task automatic plain_beat(input logic last, input logic [31:0] tok, input logic digest);
        token_beat_t b;
        b            = filler_beat();
        b.last_token = last;
        b.token_id   = tok;
        b.is_digest  = digest;
        drive_beat(b);
    endtask

    task automatic start_beat(input logic last, input logic [31:0] tok, input logic digest,
                              input logic [8:0] count, input logic [63:0] parent,
                              input logic salt_on, input logic [63:0] salt,
                              input logic adapter_on, input logic [63:0] adapter);
        token_beat_t b;
        b.first_token = 1'b1;
        b.last_token  = last;
        b.token_id    = tok;
        b.is_digest   = digest;
        b.token_count = count;
        b.parent_hash = parent;
        b.has_salt    = salt_on;
        b.salt_id     = salt;
        b.has_adapter = adapter_on;
        b.adapter_id  = adapter;
        drive_beat(b);
    endtask

    // Park the sender until every key in flight has come back.
    task automatic drain_keys();
        @(negedge clk);
        tok_ch.valid = 1'b0;
        wait (pending == 0);
    endtask

    // One random block. Closed blocks end on a last beat; open ones do not,
    // so the next beats either chain on or get restarted by a block start.
    task automatic random_block(input bit closed);
        int          n;
        int          r;
        int          digest_at;
        logic [8:0]  count;
        logic        digest;
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            n = 256;
        end
        else if (r < 20)
        begin
            n = $urandom_range(9, 40);
        end
        else
        begin
            n = $urandom_range(1, 6);
        end
        // the count field is never checked against the beats, so stray
        // values (zero and above the cap included) are fair game
        count     = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511)) : 9'(n);
        digest_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++)
        begin
            digest = (i == digest_at) || (digest_at >= 0 && i > digest_at &&
                                          $urandom_range(0, 3) == 0);
            if (i == 0)
            begin
                start_beat(closed && n == 1, $urandom, digest, count, pick_word(),
                           1'($urandom_range(0, 1)), pick_word(),
                           1'($urandom_range(0, 1)), pick_word());
            end
            else
            begin
                plain_beat(closed && i == n - 1, $urandom, digest);
            end
        end
    endtask

    // Result side: per key, idle a random number of cycles, then take it.
    initial
    begin
        int gap;
        hash_ch.ready = 1'b0;
        keys_taken    = 0;
        sink_mode     = 1;
        @(posedge rst_n);
        forever
        begin
            if (keys_taken % 40 == 0)
            begin
                sink_mode = $urandom_range(0, 2);
            end
            gap = idle_gap(sink_mode);
            if (gap > 0)
            begin
                @(negedge clk);
                hash_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            hash_ch.ready = 1'b1;
            do @(posedge clk); while (!hash_ch.valid);
            keys_taken++;
        end
    end

    initial
    begin
        int sel;
        int k;
        int next_drain;

        tok_ch.valid       = 1'b0;
        tok_ch.first_token = 1'b0;
        tok_ch.last_token  = 1'b0;
        tok_ch.token_id    = '0;
        tok_ch.is_digest   = 1'b0;
        tok_ch.token_count = '0;
        tok_ch.parent_hash = '0;
        tok_ch.has_salt    = 1'b0;
        tok_ch.salt_id     = '0;
        tok_ch.has_adapter = 1'b0;
        tok_ch.adapter_id  = '0;
        beats_sent     = 0;
        live_beats     = 0;
        blocks_started = 0;
        digest_beats   = 0;
        skipping       = 1'b0;
        src_mode       = 0;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---------------- directed opening ----------------
        // tokens before any block start fold into the reset seed
        plain_beat(1'b0, 32'h0000_0001, 1'b0);
        plain_beat(1'b1, 32'hFFFF_FFFF, 1'b0);
        // one-beat root block: salt and adapter both folded, all-ones words
        start_beat(1'b1, 32'h7FFF_FFFF, 1'b0, 9'd1, 64'h0, 1'b1, '1, 1'b1, '1);
        // count over the cap saturates; nonzero parent so the salt is skipped
        start_beat(1'b0, 32'h8000_0000, 1'b0, 9'h1FF, '1, 1'b1, random_word(),
                   1'b0, random_word());
        plain_beat(1'b0, 32'h0000_0000, 1'b0);
        plain_beat(1'b1, 32'h1234_5678, 1'b0);
        // count of zero, root without salt, adapter id of zero still folded
        start_beat(1'b0, $urandom, 1'b0, 9'd0, 64'h0, 1'b0, random_word(), 1'b1, 64'h0);
        plain_beat(1'b1, 32'hFFFF_FFFF, 1'b0);
        // counts right at and just past the cap; a zero salt on a root
        start_beat(1'b1, $urandom, 1'b0, 9'd256, random_word(), 1'b0, '0, 1'b1,
                   random_word());
        start_beat(1'b1, $urandom, 1'b0, 9'd257, 64'h0, 1'b1, 64'h0, 1'b0, '0);
        // digest on the closing beat
        start_beat(1'b0, $urandom, 1'b0, 9'd2, random_word(), 1'b1, random_word(),
                   1'b1, random_word());
        plain_beat(1'b1, $urandom, 1'b1);
        // digest on the opening beat; the rest of the block is skipped
        start_beat(1'b0, $urandom, 1'b1, 9'd3, 64'h0, 1'b1, random_word(), 1'b1,
                   random_word());
        plain_beat(1'b0, $urandom, 1'b0);
        plain_beat(1'b1, $urandom, 1'b0);
        // a new start clears the digest flag
        start_beat(1'b1, $urandom, 1'b0, 9'd1, random_word(), 1'b0, '0, 1'b1, '1);
        // beats after a last beat with no new start chain on, adapter dropped
        plain_beat(1'b0, $urandom, 1'b0);
        plain_beat(1'b1, $urandom, 1'b0);
        // a start in the middle of a block throws the old seed away
        start_beat(1'b0, $urandom, 1'b0, 9'd2, 64'h0, 1'b1, random_word(), 1'b1,
                   random_word());
        start_beat(1'b1, $urandom, 1'b0, 9'd1, '1, 1'b0, '0, 1'b0, '0);
        // digest, then a stray digest-free beat is still ignored
        start_beat(1'b0, $urandom, 1'b0, 9'd3, random_word(), 1'b0, '0, 1'b0, '0);
        plain_beat(1'b0, $urandom, 1'b1);
        plain_beat(1'b1, $urandom, 1'b0);

        // sender holds off until every key is back
        drain_keys();

        // ---------------- random blocks ----------------
        next_drain = live_beats + DRAIN_EVERY;
        while (live_beats < LIVE_BEAT_GOAL)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 78)
            begin
                random_block(1'b1);
            end
            else if (sel < 88)
            begin
                // stray beats with no block start
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                begin
                    plain_beat((i == k - 1) ? 1'($urandom_range(0, 1)) : 1'b0, $urandom,
                               1'($urandom_range(0, 19) == 0));
                end
            end
            else
            begin
                random_block(1'b0);
            end
            if (live_beats >= next_drain)
            begin
                drain_keys();
                next_drain = live_beats + DRAIN_EVERY;
            end
        end

        @(negedge clk);
        tok_ch.valid = 1'b0;
        wait (pending == 0);
        // beats without a last beat may still be in the back end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d token beats (%0d folded or flagged), %0d block starts, %0d digests.",
                 beats_sent, live_beats, blocks_started, digest_beats);
        $display("Checked %0d block keys, %0d of them incompatible.",
                 hashes_checked, aborted_blocks);
        if (errors == 0 && pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: token_block_chain_hash.f
design/tbch_pkg.sv
design/tbch_if.sv
design/tbch_front.sv
design/tbch_queue.sv
design/tbch_back.sv
design/token_block_chain_hash.sv
tb/tbch_hash_checker.sv
tb/token_block_chain_hash_test.sv
